/* rtl/core/kst_pkg.sv */
// Shared widths, status codes and saturation bounds of the keyed sum table.
// No dependencies; imported by the table top level.
`default_nettype none

package kst_pkg;

	localparam int KEY_W0     = 64;
	localparam int KEY_W3     = 40;
	localparam int KEY_NBYTES = 29;
	localparam int KEY_W      = 8 * KEY_NBYTES;
	localparam int QTY_W      = 32;
	localparam int PRICE_W    = 40;
	localparam int SUM_W      = 48;
	localparam int STAT_W     = 3;
	localparam int SLOT_W     = 6;

	localparam logic [STAT_W-1:0] STATUS_ADDED    = 3'd0;
	localparam logic [STAT_W-1:0] STATUS_INSERTED = 3'd1;
	localparam logic [STAT_W-1:0] STATUS_DROPPED  = 3'd2;
	localparam logic [STAT_W-1:0] STATUS_ENTRY    = 3'd3;
	localparam logic [STAT_W-1:0] STATUS_EMPTY    = 3'd4;

	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_REPORT = 1'b1;

	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

`default_nettype wire

/* rtl/core/keyed_sum_aggregation_table_top.sv */
// Group-by-key sum table: sequencer, key/total memories and one shared
// saturating adder. Depends on kst_pkg.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    func, key_word0..3, quantity, price_cents
// result    out        out_valid/out_ready  status, slot, out_key0..3, sum_quantity,
//                                           sum_cents, last
//
// A record scans the stored keys one per cycle through the key memory read port;
// a miss then inserts the key, or drops it on a full table, and a hit adds
// quantity and then cents through the saturating adder (ADDQ, ADDC).
// Report: each entry is read (RPT_RD) and then emitted (RPT_EMIT), one result each.
// Reset clears the control state, index and entry count; memories are never cleared.
// in_ready is high only between items; a stalled result holds the sequencer.
`default_nettype none

module keyed_sum_aggregation_table_top #(
	parameter int ENTRIES   = 64,
	parameter int KEY_BYTES = 29
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                func,
	input  wire  [kst_pkg::KEY_W0-1:0]         key_word0,
	input  wire  [kst_pkg::KEY_W0-1:0]         key_word1,
	input  wire  [kst_pkg::KEY_W0-1:0]         key_word2,
	input  wire  [kst_pkg::KEY_W3-1:0]         key_word3,
	input  wire  signed [kst_pkg::QTY_W-1:0]   quantity,
	input  wire  signed [kst_pkg::PRICE_W-1:0] price_cents,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [kst_pkg::STAT_W-1:0]         status,
	output logic [kst_pkg::SLOT_W-1:0]         slot,
	output logic [kst_pkg::KEY_W0-1:0]         out_key0,
	output logic [kst_pkg::KEY_W0-1:0]         out_key1,
	output logic [kst_pkg::KEY_W0-1:0]         out_key2,
	output logic [kst_pkg::KEY_W3-1:0]         out_key3,
	output logic signed [kst_pkg::SUM_W-1:0]   sum_quantity,
	output logic signed [kst_pkg::SUM_W-1:0]   sum_cents,
	output logic                               last
);

	import kst_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_ADDQ     = 3'd2;
	localparam logic [2:0] S_ADDC     = 3'd3;
	localparam logic [2:0] S_EMIT     = 3'd4;
	localparam logic [2:0] S_RPT_RD   = 3'd5;
	localparam logic [2:0] S_RPT_EMIT = 3'd6;

	// control state
	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic             chk_v_q;
	logic             out_valid_q;

	// item and result staging
	logic [KEY_W-1:0]  key_q;
	logic [SUM_W-1:0]  in_qty_q;
	logic [SUM_W-1:0]  in_cents_q;
	logic [IDX_W-1:0]  chk_idx_q;
	logic [STAT_W-1:0] res_status_q;
	logic [IDX_W-1:0]  res_slot_q;
	logic [SUM_W-1:0]  acc_qty_q;
	logic [SUM_W-1:0]  acc_cents_q;

	// memories and their registered read data
	logic [KEY_W-1:0] key_mem   [ENTRIES];
	logic [SUM_W-1:0] qty_mem   [ENTRIES];
	logic [SUM_W-1:0] cents_mem [ENTRIES];
	logic [KEY_W-1:0] rd_key_q;
	logic [SUM_W-1:0] rd_qty_q;
	logic [SUM_W-1:0] rd_cents_q;

	// output register
	logic [STAT_W-1:0] status_q;
	logic [SLOT_W-1:0] slot_q;
	logic [KEY_W-1:0]  okey_q;
	logic [SUM_W-1:0]  osum_qty_q;
	logic [SUM_W-1:0]  osum_cents_q;
	logic              last_q;

	logic [KEY_W-1:0]      raw_key;
	logic [KEY_W-1:0]      canon_key;
	logic [KEY_NBYTES-1:0] byte_nz;
	logic                  in_acc;
	logic                  out_free;
	logic                  key_hit;
	logic                  more;
	logic                  issue;
	logic                  rd_en;
	logic                  wr_new;
	logic                  full;
	logic                  rpt_load;
	logic                  emit_load;
	logic                  rpt_last;
	logic [SUM_W-1:0]      add_a;
	logic [SUM_W-1:0]      add_b;
	logic [SUM_W:0]        add_sum;
	logic [SUM_W-1:0]      add_sat;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Canonical key: a byte survives only if it and every byte below it are non-zero.
	assign raw_key = {key_word3, key_word2, key_word1, key_word0};

	always_comb begin
		for (int b = 0; b < KEY_NBYTES; b++) begin
			byte_nz[b] = |raw_key[8*b +: 8];
		end
		for (int b = 0; b < KEY_NBYTES; b++) begin
			if ((b < KEY_BYTES) && ((byte_nz | ({KEY_NBYTES{1'b1}} << (b + 1))) ==
					{KEY_NBYTES{1'b1}})) begin
				canon_key[8*b +: 8] = raw_key[8*b +: 8];
			end else begin
				canon_key[8*b +: 8] = 8'h00;
			end
		end
	end

	assign key_hit  = chk_v_q && (rd_key_q == key_q);
	assign more     = (idx_q < count_q);
	assign full     = (count_q == CNT_W'(ENTRIES));
	assign issue    = (state_q == S_SCAN) && !key_hit && more;
	assign rd_en    = issue || (state_q == S_RPT_RD);
	assign wr_new   = (state_q == S_SCAN) && !key_hit && !more && !chk_v_q && !full;
	assign rpt_load = (state_q == S_RPT_EMIT) && out_free;
	assign emit_load = (state_q == S_EMIT) && out_free;
	assign rpt_last = ((idx_q + CNT_W'(1)) == count_q);

	// Shared saturating adder: quantity in ADDQ, cents in ADDC.
	assign add_a   = (state_q == S_ADDQ) ? rd_qty_q : rd_cents_q;
	assign add_b   = (state_q == S_ADDQ) ? in_qty_q : in_cents_q;
	assign add_sum = {add_a[SUM_W-1], add_a} + {add_b[SUM_W-1], add_b};

	always_comb begin
		if (add_sum[SUM_W] != add_sum[SUM_W-1]) begin
			add_sat = add_sum[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			add_sat = add_sum[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			chk_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_load || rpt_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						idx_q   <= '0;
						chk_v_q <= 1'b0;
						if (func == FUNC_RECORD) begin
							state_q <= S_SCAN;
						end else if (count_q == '0) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_RPT_RD;
						end
					end
				end
				S_SCAN: begin
					if (key_hit) begin
						chk_v_q <= 1'b0;
						state_q <= S_ADDQ;
					end else if (more) begin
						chk_v_q <= 1'b1;
						idx_q   <= idx_q + CNT_W'(1);
					end else if (chk_v_q) begin
						chk_v_q <= 1'b0;
					end else begin
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= S_EMIT;
					end
				end
				S_ADDQ: state_q <= S_ADDC;
				S_ADDC: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RPT_RD: state_q <= S_RPT_EMIT;
				S_RPT_EMIT: begin
					if (out_free) begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= rpt_last ? S_IDLE : S_RPT_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q        <= (func == FUNC_RECORD) ? canon_key : '0;
			in_qty_q     <= {{(SUM_W-QTY_W){quantity[QTY_W-1]}}, quantity};
			in_cents_q   <= {{(SUM_W-PRICE_W){price_cents[PRICE_W-1]}}, price_cents};
			res_status_q <= STATUS_EMPTY;
			res_slot_q   <= '0;
			acc_qty_q    <= '0;
			acc_cents_q  <= '0;
		end
		if (issue) begin
			chk_idx_q <= idx_q[IDX_W-1:0];
		end
		if ((state_q == S_SCAN) && !key_hit && !more && !chk_v_q) begin
			if (full) begin
				res_status_q <= STATUS_DROPPED;
				res_slot_q   <= '0;
				acc_qty_q    <= '0;
				acc_cents_q  <= '0;
			end else begin
				res_status_q <= STATUS_INSERTED;
				res_slot_q   <= count_q[IDX_W-1:0];
				acc_qty_q    <= in_qty_q;
				acc_cents_q  <= in_cents_q;
			end
		end
		if (state_q == S_ADDQ) begin
			acc_qty_q <= add_sat;
		end
		if (state_q == S_ADDC) begin
			acc_cents_q  <= add_sat;
			res_status_q <= STATUS_ADDED;
			res_slot_q   <= chk_idx_q;
		end
		if (emit_load) begin
			status_q     <= res_status_q;
			slot_q       <= SLOT_W'(res_slot_q);
			okey_q       <= key_q;
			osum_qty_q   <= acc_qty_q;
			osum_cents_q <= acc_cents_q;
			last_q       <= 1'b1;
		end else if (rpt_load) begin
			status_q     <= STATUS_ENTRY;
			slot_q       <= SLOT_W'(idx_q[IDX_W-1:0]);
			okey_q       <= rd_key_q;
			osum_qty_q   <= rd_qty_q;
			osum_cents_q <= rd_cents_q;
			last_q       <= rpt_last;
		end
	end

	// Memories: one write port each, one shared read address.
	always_ff @(posedge clk) begin
		if (wr_new) begin
			key_mem[count_q[IDX_W-1:0]] <= key_q;
		end
		if (wr_new) begin
			qty_mem[count_q[IDX_W-1:0]] <= in_qty_q;
		end else if (state_q == S_ADDQ) begin
			qty_mem[chk_idx_q] <= add_sat;
		end
		if (wr_new) begin
			cents_mem[count_q[IDX_W-1:0]] <= in_cents_q;
		end else if (state_q == S_ADDC) begin
			cents_mem[chk_idx_q] <= add_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_q   <= key_mem[idx_q[IDX_W-1:0]];
			rd_qty_q   <= qty_mem[idx_q[IDX_W-1:0]];
			rd_cents_q <= cents_mem[idx_q[IDX_W-1:0]];
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slot         = slot_q;
	assign out_key0     = okey_q[KEY_W0-1:0];
	assign out_key1     = okey_q[2*KEY_W0-1:KEY_W0];
	assign out_key2     = okey_q[3*KEY_W0-1:2*KEY_W0];
	assign out_key3     = okey_q[KEY_W-1:3*KEY_W0];
	assign sum_quantity = osum_qty_q;
	assign sum_cents    = osum_cents_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table size");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_new |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not advance entry count");

	a_compare_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_v_q |-> (state_q == S_SCAN))
		else $error("pending key compare outside scan");
`endif

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the keyed sum table: sends record and report requests over
// valid/ready, predicts every result row and compares it field by field.
// Depends on kst_pkg and keyed_sum_aggregation_table_top.

module testbench;
	import kst_pkg::*;

	localparam int TABLE_DEPTH  = 64;
	localparam int BIG_ROUNDS   = 6;
	localparam int POOL_SIZE    = 24;
	localparam int RANDOM_ITEMS = 30;
	localparam int LONG_HOLD    = 400;

	localparam logic signed [QTY_W-1:0]   QTY_TOP      = {1'b0, {(QTY_W-1){1'b1}}};
	localparam logic signed [QTY_W-1:0]   QTY_BOTTOM   = {1'b1, {(QTY_W-1){1'b0}}};
	localparam logic signed [PRICE_W-1:0] PRICE_TOP    = {1'b0, {(PRICE_W-1){1'b1}}};
	localparam logic signed [PRICE_W-1:0] PRICE_BOTTOM = {1'b1, {(PRICE_W-1){1'b0}}};

	typedef struct {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  name;
		logic [SUM_W-1:0]  qty;
		logic [SUM_W-1:0]  cents;
		logic              last;
	} tally_row_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_THREE_IN_FOUR, RX_ONE_IN_FOUR} rx_mode_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic                      func        = FUNC_RECORD;
	logic [KEY_W0-1:0]         key_word0   = '0;
	logic [KEY_W0-1:0]         key_word1   = '0;
	logic [KEY_W0-1:0]         key_word2   = '0;
	logic [KEY_W3-1:0]         key_word3   = '0;
	logic signed [QTY_W-1:0]   quantity    = '0;
	logic signed [PRICE_W-1:0] price_cents = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic [STAT_W-1:0]         status;
	logic [SLOT_W-1:0]         slot;
	logic [KEY_W0-1:0]         out_key0;
	logic [KEY_W0-1:0]         out_key1;
	logic [KEY_W0-1:0]         out_key2;
	logic [KEY_W3-1:0]         out_key3;
	logic signed [SUM_W-1:0]   sum_quantity;
	logic signed [SUM_W-1:0]   sum_cents;
	logic                      last;

	// predicted table contents, in insertion order
	logic [KEY_W-1:0]        ledger_key   [TABLE_DEPTH];
	logic signed [SUM_W-1:0] ledger_qty   [TABLE_DEPTH];
	logic signed [SUM_W-1:0] ledger_cents [TABLE_DEPTH];
	int                      ledger_used = 0;
	tally_row_t              due_rows [$];
	logic [KEY_W-1:0]        name_pool [POOL_SIZE];

	int       fail_count    = 0;
	int       sent_count    = 0;
	int       checked_count = 0;
	int       burst_left    = 0;
	int       hold_req      = 0;
	int       hold_left     = 0;
	int       rx_tick       = 0;
	bit       idle_en       = 1'b1;
	bit       stall_en      = 1'b1;
	rx_mode_t rx_mode       = RX_OPEN;

	keyed_sum_aggregation_table_top #(
		.ENTRIES   (TABLE_DEPTH),
		.KEY_BYTES (KEY_NBYTES)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.key_word0    (key_word0),
		.key_word1    (key_word1),
		.key_word2    (key_word2),
		.key_word3    (key_word3),
		.quantity     (quantity),
		.price_cents  (price_cents),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot         (slot),
		.out_key0     (out_key0),
		.out_key1     (out_key1),
		.out_key2     (out_key2),
		.out_key3     (out_key3),
		.sum_quantity (sum_quantity),
		.sum_cents    (sum_cents),
		.last         (last)
	);

	always #1 clk = ~clk;

	// Cut the name at its first zero byte.
	function automatic logic [KEY_W-1:0] canon_name(input logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] name;
		logic             ended;
		name  = '0;
		ended = 1'b0;
		for (int b = 0; b < KEY_NBYTES; b++) begin
			if (raw[8*b +: 8] == 8'd0)
				ended = 1'b1;
			if (!ended)
				name[8*b +: 8] = raw[8*b +: 8];
		end
		return name;
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_total(input logic signed [SUM_W-1:0] acc,
			input longint add);
		longint s;
		s = longint'(acc) + add;
		if (s > longint'($signed(SUM_MAX)))
			s = longint'($signed(SUM_MAX));
		else if (s < longint'($signed(SUM_MIN)))
			s = longint'($signed(SUM_MIN));
		return s[SUM_W-1:0];
	endfunction

	function automatic logic [KEY_W-1:0] make_name(input int len);
		logic [KEY_W-1:0] name;
		name = '0;
		for (int b = 0; b < len && b < KEY_NBYTES; b++)
			name[8*b +: 8] = 8'($urandom_range(1, 255));
		return name;
	endfunction

	// Fill the bytes after the terminator with junk.
	function automatic logic [KEY_W-1:0] dress_name(input logic [KEY_W-1:0] name);
		logic [KEY_W-1:0] raw;
		logic             ended;
		raw   = name;
		ended = 1'b0;
		for (int b = 0; b < KEY_NBYTES; b++) begin
			if (ended)
				raw[8*b +: 8] = 8'($urandom_range(0, 255));
			else if (name[8*b +: 8] == 8'd0)
				ended = 1'b1;
		end
		return raw;
	endfunction

	function automatic logic [KEY_W-1:0] noise_name();
		logic [KEY_W-1:0] raw;
		for (int b = 0; b < KEY_NBYTES; b++)
			raw[8*b +: 8] = 8'($urandom_range(0, 255));
		return raw;
	endfunction

	function automatic logic signed [QTY_W-1:0] pick_qty();
		case ($urandom_range(0, 9))
			0:       return QTY_TOP;
			1:       return QTY_BOTTOM;
			2:       return QTY_W'($signed($urandom_range(0, 200)) - 100);
			default: return QTY_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [PRICE_W-1:0] pick_price();
		case ($urandom_range(0, 9))
			0:       return PRICE_TOP;
			1:       return PRICE_BOTTOM;
			2:       return PRICE_W'($signed($urandom_range(0, 20000)) - 10000);
			default: return {8'($urandom_range(0, 255)), 32'($urandom)};
		endcase
	endfunction

	// Apply one accepted request to the predicted table and queue its result rows.
	task automatic post_request(input logic f, input logic [KEY_W-1:0] raw,
			input logic signed [QTY_W-1:0] q, input logic signed [PRICE_W-1:0] p);
		tally_row_t       row;
		logic [KEY_W-1:0] name;
		int               hit;
		if (f == FUNC_REPORT) begin
			if (ledger_used == 0) begin
				row.status = STATUS_EMPTY;
				row.slot   = '0;
				row.name   = '0;
				row.qty    = '0;
				row.cents  = '0;
				row.last   = 1'b1;
				due_rows.push_back(row);
			end else begin
				for (int i = 0; i < ledger_used; i++) begin
					row.status = STATUS_ENTRY;
					row.slot   = SLOT_W'(i);
					row.name   = ledger_key[i];
					row.qty    = ledger_qty[i];
					row.cents  = ledger_cents[i];
					row.last   = (i == ledger_used - 1);
					due_rows.push_back(row);
				end
			end
		end else begin
			name = canon_name(raw);
			hit  = -1;
			for (int i = 0; i < ledger_used; i++)
				if (hit < 0 && ledger_key[i] == name)
					hit = i;
			row.name = name;
			row.last = 1'b1;
			if (hit >= 0) begin
				ledger_qty[hit]   = sat_total(ledger_qty[hit], longint'(q));
				ledger_cents[hit] = sat_total(ledger_cents[hit], longint'(p));
				row.status = STATUS_ADDED;
				row.slot   = SLOT_W'(hit);
				row.qty    = ledger_qty[hit];
				row.cents  = ledger_cents[hit];
			end else if (ledger_used >= TABLE_DEPTH) begin
				row.status = STATUS_DROPPED;
				row.slot   = '0;
				row.qty    = '0;
				row.cents  = '0;
			end else begin
				ledger_key[ledger_used]   = name;
				ledger_qty[ledger_used]   = q;
				ledger_cents[ledger_used] = p;
				row.status = STATUS_INSERTED;
				row.slot   = SLOT_W'(ledger_used);
				row.qty    = ledger_qty[ledger_used];
				row.cents  = ledger_cents[ledger_used];
				ledger_used++;
			end
			due_rows.push_back(row);
		end
	endtask

	// Offer one request and hold it until accepted; valid stays high on return.
	task automatic send_item(input logic f, input logic [KEY_W-1:0] raw,
			input logic signed [QTY_W-1:0] q, input logic signed [PRICE_W-1:0] p);
		if (idle_en && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40)
			                                         : $urandom_range(1, 6);
		end
		if (burst_left > 0)
			burst_left--;
		func        <= f;
		key_word0   <= raw[KEY_W0-1:0];
		key_word1   <= raw[2*KEY_W0-1:KEY_W0];
		key_word2   <= raw[3*KEY_W0-1:2*KEY_W0];
		key_word3   <= raw[KEY_W-1:3*KEY_W0];
		quantity    <= q;
		price_cents <= p;
		in_valid    <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		post_request(f, raw, q, p);
		sent_count++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (due_rows.size() != 0);
	endtask

	function automatic void match_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			fail_count++;
			$error("%s: expected %h, got %h", field, want, got);
		end
	endfunction

	task automatic check_row();
		tally_row_t want;
		if (due_rows.size() == 0) begin
			fail_count++;
			$error("result with no request pending: status %0d slot %0d", status, slot);
		end else begin
			want = due_rows.pop_front();
			checked_count++;
			match_field("status", want.status, status);
			match_field("slot", want.slot, slot);
			match_field("out_key0", want.name[KEY_W0-1:0], out_key0);
			match_field("out_key1", want.name[2*KEY_W0-1:KEY_W0], out_key1);
			match_field("out_key2", want.name[3*KEY_W0-1:2*KEY_W0], out_key2);
			match_field("out_key3", want.name[KEY_W-1:3*KEY_W0], out_key3);
			match_field("sum_quantity", want.qty, $unsigned(sum_quantity));
			match_field("sum_cents", want.cents, $unsigned(sum_cents));
			match_field("last", want.last, last);
		end
	endtask

	// Result side: check, then pick the next ready from the stall pattern.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_row();
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			rx_tick++;
			if (rx_tick % 48 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!stall_en) begin
				out_ready <= 1'b1;
			end else begin
				case (rx_mode)
					RX_OPEN:          out_ready <= 1'b1;
					RX_COIN:          out_ready <= 1'($urandom_range(0, 1));
					RX_THREE_IN_FOUR: out_ready <= (rx_tick % 4 != 0);
					default:          out_ready <= (rx_tick % 4 == 0);
				endcase
			end
		end
	end

	task automatic test_empty_report();
		send_item(FUNC_REPORT, noise_name(), pick_qty(), pick_price());
		wait_drained();
	endtask

	// Stack extreme amounts on one entry back to back, cents up then down.
	task automatic test_large_totals();
		logic [KEY_W-1:0] name;
		name        = '0;
		name[39:0]  = 40'h6C_61_74_6F_74;
		idle_en     = 1'b0;
		stall_en    = 1'b0;
		for (int n = 0; n < BIG_ROUNDS; n++)
			send_item(FUNC_RECORD, name, QTY_TOP,
			          (n < BIG_ROUNDS / 2) ? PRICE_TOP : PRICE_BOTTOM);
		send_item(FUNC_RECORD, dress_name(name), QTY_BOTTOM, PRICE_TOP);
		send_item(FUNC_REPORT, name, '0, '0);
		wait_drained();
		idle_en  = 1'b1;
		stall_en = 1'b1;
	endtask

	task automatic test_key_forms();
		logic [KEY_W-1:0] raw;
		send_item(FUNC_RECORD, '0, '0, '0);
		send_item(FUNC_RECORD, '1, QTY_TOP, PRICE_TOP);
		send_item(FUNC_RECORD, '1, QTY_BOTTOM, PRICE_BOTTOM);
		// junk behind a leading terminator folds onto the empty name
		raw = '1;
		raw[7:0] = 8'h00;
		send_item(FUNC_RECORD, raw, -32'sd1, -40'sd1);
		raw = '1;
		raw[23:0] = 24'h00_6261;
		send_item(FUNC_RECORD, raw, 32'sd7, 40'sd1999);
		raw = '0;
		raw[15:0] = 16'h6261;
		send_item(FUNC_RECORD, raw, -32'sd3, -40'sd250);
		// terminator on each word boundary, then on the last byte
		for (int b = 8; b < KEY_NBYTES; b += 8) begin
			raw = '1;
			raw[8*b +: 8] = 8'h00;
			send_item(FUNC_RECORD, raw, pick_qty(), pick_price());
		end
		raw = '1;
		raw[8*(KEY_NBYTES-1) +: 8] = 8'h00;
		send_item(FUNC_RECORD, raw, pick_qty(), pick_price());
		send_item(FUNC_RECORD, dress_name(canon_name(raw)), pick_qty(), pick_price());
		send_item(FUNC_REPORT, '1, QTY_TOP, PRICE_TOP);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int pick;
		for (int p = 0; p < POOL_SIZE; p++)
			name_pool[p] = make_name($urandom_range(0, KEY_NBYTES));
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				send_item(FUNC_REPORT, noise_name(), pick_qty(), pick_price());
			else if (pick < 78)
				send_item(FUNC_RECORD, dress_name(name_pool[$urandom_range(0, POOL_SIZE-1)]),
				          pick_qty(), pick_price());
			else
				send_item(FUNC_RECORD, noise_name(), pick_qty(), pick_price());
		end
		wait_drained();
	endtask

	task automatic test_table_full();
		while (ledger_used < TABLE_DEPTH)
			send_item(FUNC_RECORD, make_name(KEY_NBYTES), pick_qty(), pick_price());
		repeat (4)
			send_item(FUNC_RECORD, dress_name(make_name($urandom_range(1, KEY_NBYTES))),
			          pick_qty(), pick_price());
		// a hit on the final slot still lands when full
		send_item(FUNC_RECORD, dress_name(ledger_key[TABLE_DEPTH-1]), pick_qty(), pick_price());
		send_item(FUNC_REPORT, noise_name(), pick_qty(), pick_price());
		wait_drained();
	endtask

	// Hold the result side while more requests queue up behind a full report.
	task automatic test_stalled_output();
		hold_req = LONG_HOLD;
		send_item(FUNC_REPORT, noise_name(), pick_qty(), pick_price());
		send_item(FUNC_RECORD, dress_name(ledger_key[0]), pick_qty(), pick_price());
		send_item(FUNC_RECORD, make_name(KEY_NBYTES), pick_qty(), pick_price());
		send_item(FUNC_RECORD, dress_name(ledger_key[TABLE_DEPTH/2]), pick_qty(), pick_price());
		send_item(FUNC_REPORT, noise_name(), pick_qty(), pick_price());
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_report();
		test_large_totals();
		test_key_forms();
		test_random_traffic();
		test_table_full();
		test_stalled_output();
		repeat (80) @(posedge clk);
		if (due_rows.size() != 0) begin
			fail_count++;
			$error("%0d result rows never arrived", due_rows.size());
		end
		$display("Sent %0d requests, checked %0d rows: empty and full table, name forms,",
		         sent_count, checked_count);
		$display("extreme totals, random records and reports, long output stall.");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
